[hdl/flow_key_fasthash_unit_macros.svh]
// Assertion macros for the flow key hash unit.
`ifndef FLOW_KEY_FASTHASH_UNIT_MACROS_SVH
`define FLOW_KEY_FASTHASH_UNIT_MACROS_SVH

`ifndef SYNTHESIS

`define FKF_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("flow key hash assertion failed");

`define FKF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("flow key hash next-cycle assertion failed");

`else

`define FKF_ASSERT(lbl, clk, rst, prop)
`define FKF_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

[hdl/fkf_pkg.sv]
// Types and constants shared by the flow key hash unit.
`default_nettype none

package fkf_pkg;

   localparam int WORD_BITS = 64;
   localparam int HALF_BITS = 32;

   localparam logic [WORD_BITS-1:0] MIX_MUL    = 64'h2127599bf4325c37;
   localparam logic [WORD_BITS-1:0] ROUND_MUL  = 64'h880355f21e6d1965;
   localparam logic [WORD_BITS-1:0] KEY_BYTES  = 64'd13;
   localparam logic [WORD_BITS-1:0] INIT_MIX   = KEY_BYTES * ROUND_MUL;
   localparam logic [HALF_BITS-1:0] SEED_RESET = 32'h9747b28c;
   localparam int MIX_SHIFT_A = 23;
   localparam int MIX_SHIFT_B = 47;

   typedef struct packed {
      logic [31:0] source_address;
      logic [31:0] destination_address;
      logic [15:0] source_port;
      logic [15:0] destination_port;
      logic [7:0]  protocol_number;
   } req_type;

   typedef struct packed {
      logic [63:0] hash_wide;
      logic [31:0] hash_narrow;
   } rsp_type;

endpackage

`default_nettype wire

[hdl/fkf_mul64.sv]
// Two-stage 64x64 multiplier keeping the low 64 bits of the product.
`default_nettype none

module fkf_mul64 (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   input  wire logic [fkf_pkg::WORD_BITS-1:0] a,
   input  wire logic [fkf_pkg::WORD_BITS-1:0] b,
   output logic                               out_valid,
   output logic      [fkf_pkg::WORD_BITS-1:0] product
);
   import fkf_pkg::*;

   logic                 pp_valid_ff;
   logic [WORD_BITS-1:0] lolo_ff, lolo_in;
   logic [HALF_BITS-1:0] cross_a_ff, cross_a_in;
   logic [HALF_BITS-1:0] cross_b_ff, cross_b_in;
   logic                 out_valid_ff;
   logic [WORD_BITS-1:0] product_ff, product_in;

   // cross terms only matter mod 2^32 since they land in the upper half
   always_comb begin
      lolo_in    = WORD_BITS'(a[HALF_BITS-1:0]) * WORD_BITS'(b[HALF_BITS-1:0]);
      cross_a_in = a[HALF_BITS-1:0] * b[WORD_BITS-1:HALF_BITS];
      cross_b_in = a[WORD_BITS-1:HALF_BITS] * b[HALF_BITS-1:0];
      product_in = lolo_ff + {cross_a_ff + cross_b_ff, {HALF_BITS{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pp_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         pp_valid_ff  <= in_valid;
         out_valid_ff <= pp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      lolo_ff    <= lolo_in;
      cross_a_ff <= cross_a_in;
      cross_b_ff <= cross_b_in;
      product_ff <= product_in;
   end

   assign out_valid = out_valid_ff;
   assign product   = product_ff;

endmodule

`default_nettype wire

[hdl/flow_key_fasthash_unit.sv]
// Flow key hash unit: fasthash64 of a 13-byte 5-tuple plus 32-bit fold.
// Response path: body and tail mix multiplies, then round1, round2 and final multiplies, then the rsp_strobe register.
// Throughput: one beat per cycle while busy is low; four chained 64-bit multiplies, two stages each.
// busy is high during reset, clears on the edge after reset is released, then stays low.
// Reset clears the pipeline valid bits and loads the seed with its default.
`default_nettype none
`include "flow_key_fasthash_unit_macros.svh"

module flow_key_fasthash_unit (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire fkf_pkg::req_type req_data,
   output logic                  rsp_strobe,
   output fkf_pkg::rsp_type      rsp_data,
   input  wire logic             csr_write_enable,
   input  wire logic [31:0]      csr_write_data
);
   import fkf_pkg::*;

   logic                 busy_ff;
   logic [HALF_BITS-1:0] seed_ff, seed_in;
   logic                 accept;
   logic [WORD_BITS-1:0] body, tail, body_x, tail_x;
   logic                 body_valid, tail_valid;
   logic [WORD_BITS-1:0] body_p, tail_p, body_m, tail_m;
   logic [WORD_BITS-1:0] tail_d1_ff, tail_d2_ff;
   logic [WORD_BITS-1:0] h1, h2, fin_x, hw;
   logic                 c_valid, d_valid, e_valid;
   logic [WORD_BITS-1:0] c_p, d_p, e_p;
   logic                 rsp_strobe_ff;
   rsp_type              rsp_data_ff, rsp_data_in;

   assign accept = start && !busy_ff;

   always_comb begin
      seed_in = csr_write_enable ? csr_write_data : seed_ff;
      body    = {req_data.destination_address, req_data.source_address};
      tail    = {24'b0, req_data.protocol_number, req_data.destination_port,
                 req_data.source_port};
      body_x  = body ^ (body >> MIX_SHIFT_A);
      tail_x  = tail ^ (tail >> MIX_SHIFT_A);
      body_m  = body_p ^ (body_p >> MIX_SHIFT_B);
      tail_m  = tail_p ^ (tail_p >> MIX_SHIFT_B);
      h1      = {{(WORD_BITS-HALF_BITS){1'b0}}, seed_ff} ^ INIT_MIX ^ body_m;
      h2      = c_p ^ tail_d2_ff;
      fin_x   = d_p ^ (d_p >> MIX_SHIFT_A);
      hw      = e_p ^ (e_p >> MIX_SHIFT_B);
      rsp_data_in.hash_wide   = hw;
      rsp_data_in.hash_narrow = hw[HALF_BITS-1:0] - hw[WORD_BITS-1:HALF_BITS];
   end

   fkf_mul64 u_mul_body (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .a         (body_x),
      .b         (MIX_MUL),
      .out_valid (body_valid),
      .product   (body_p)
   );

   fkf_mul64 u_mul_tail (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .a         (tail_x),
      .b         (MIX_MUL),
      .out_valid (tail_valid),
      .product   (tail_p)
   );

   fkf_mul64 u_mul_round1 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (body_valid),
      .a         (h1),
      .b         (ROUND_MUL),
      .out_valid (c_valid),
      .product   (c_p)
   );

   fkf_mul64 u_mul_round2 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c_valid),
      .a         (h2),
      .b         (ROUND_MUL),
      .out_valid (d_valid),
      .product   (d_p)
   );

   fkf_mul64 u_mul_final (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d_valid),
      .a         (fin_x),
      .b         (MIX_MUL),
      .out_valid (e_valid),
      .product   (e_p)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b1;
         seed_ff       <= SEED_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         busy_ff       <= 1'b0;
         seed_ff       <= seed_in;
         rsp_strobe_ff <= e_valid;
      end
   end

   // tail mix waits out the first round multiply
   always_ff @(posedge clock) begin
      tail_d1_ff  <= tail_m;
      tail_d2_ff  <= tail_d1_ff;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy       = busy_ff;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   `FKF_ASSERT(a_accept_gives_rsp, clock, reset, (start && !busy) |-> ##9 rsp_strobe)
   `FKF_ASSERT(a_rsp_from_accept, clock, reset, rsp_strobe |-> $past(start && !busy, 9))
   `FKF_ASSERT(a_lanes_aligned, clock, reset, body_valid == tail_valid)
   `FKF_ASSERT_NEXT(a_busy_drops, clock, reset, !reset, !busy)

endmodule

`default_nettype wire
